### rtl/bpq_pkg.sv
// Shared types and codes for the bounded priority queue.
`default_nettype none
package bpq_pkg;

  localparam int DEF_CAPACITY = 16;

  typedef enum logic [1:0] {
    REQ_ENQUEUE = 2'd0,
    REQ_DEQUEUE = 2'd1,
    REQ_PEEK    = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_e;

  typedef struct packed {
    logic        [1:0]  req_type;
    logic signed [31:0] data_in;
    logic signed [31:0] priority_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] head_data;
    logic               queue_empty;
    logic        [1:0]  status;
  } out_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic signed [31:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

### rtl/bpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### rtl/bounded_priority_queue.sv
// Bounded priority queue kept sorted in a circular RAM, highest priority at the head.
//
// Requests arrive on the in_ channel (in_valid/in_stall, payload in_data) and each
// produces exactly one transaction on the out_ channel (out_valid/out_stall, out_data).
// Enqueue places the new entry behind all entries of equal or higher priority, so
// equal priorities leave in arrival order. Dequeue returns and removes the head, peek
// returns it in place. Overflow and underflow leave the queue unchanged.
//
// Entries live in one RAM used as a ring: dequeue only advances the head pointer.
// Enqueue walks backward from the tail, reading one entry and moving it up one slot
// per cycle until it meets an entry of equal or higher priority, then writes the new
// entry. An enqueue's result waits on the walk, so its time grows with the entries it
// passes; dequeue and peek make one RAM read, and rejected or unused requests none.
// The next request is taken only once the previous result is loaded into the output
// register.
//
// The block takes one request at a time: in_stall is high from acceptance until the
// result is loaded into the output register. A stalled result holds in that register,
// and a new request may be accepted meanwhile; its result waits until out_stall drops.
// Reset empties the queue at once; RAM contents are never read before being written.
`default_nettype none
module bounded_priority_queue #(
  parameter int CAPACITY = bpq_pkg::DEF_CAPACITY
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire bpq_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output bpq_pkg::out_t     out_data
);
  import bpq_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_PLACE = 5'b00100,
    S_HEAD  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  entry_t           new_r, new_nxt;
  out_t             res_r, res_nxt;
  out_t             out_r;
  logic             out_valid_r;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_entry;
  logic [IDX_W-1:0] rd_addr;
  logic [ENTRY_W-1:0] rd_raw;
  entry_t           rd_entry;

  logic [IDX_W-1:0] tail;
  logic [SUM_W-1:0] tail_sum;
  logic [IDX_W-1:0] cur_dec;
  logic             accept;
  logic             out_free;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(CAPACITY - 1)) begin
      return '0;
    end
    return i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    if (i == '0) begin
      return IDX_W'(CAPACITY - 1);
    end
    return i - 1'b1;
  endfunction

  bpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_entry),
    .rd_addr(rd_addr),
    .rd_data(rd_raw)
  );

  assign rd_entry = entry_t'(rd_raw);
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign cur_dec  = idx_dec(cur_r);

  // Tail slot is head + count, wrapped once.
  always_comb begin
    tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
    if (tail_sum >= SUM_W'(CAPACITY)) begin
      tail_sum = tail_sum - SUM_W'(CAPACITY);
    end
    tail = tail_sum[IDX_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    cur_nxt   = cur_r;
    left_nxt  = left_r;
    new_nxt   = new_r;
    res_nxt   = res_r;
    wr_en     = 1'b0;
    wr_addr   = cur_r;
    wr_entry  = new_r;
    rd_addr   = head_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt.head_data   = '0;
          res_nxt.queue_empty = (count_r == '0);
          res_nxt.status      = STATUS_OK;
          new_nxt.data        = in_data.data_in;
          new_nxt.prio        = in_data.priority_in;
          case (in_data.req_type)
            REQ_ENQUEUE: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                res_nxt.status = STATUS_OVERFLOW;
                state_nxt      = S_DONE;
              end else begin
                res_nxt.queue_empty = 1'b0;
                count_nxt           = count_r + 1'b1;
                cur_nxt             = tail;
                left_nxt            = count_r;
                rd_addr             = idx_dec(tail);
                state_nxt           = (count_r == '0) ? S_PLACE : S_WALK;
              end
            end
            REQ_DEQUEUE: begin
              if (count_r == '0) begin
                res_nxt.status = STATUS_UNDERFLOW;
                state_nxt      = S_DONE;
              end else begin
                res_nxt.queue_empty = (count_r == CNT_W'(1));
                head_nxt            = idx_inc(head_r);
                count_nxt           = count_r - 1'b1;
                state_nxt           = S_HEAD;
              end
            end
            REQ_PEEK: begin
              if (count_r == '0) begin
                res_nxt.status = STATUS_UNDERFLOW;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_HEAD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_WALK: begin
        // rd_entry holds the slot just below cur_r.
        wr_en = 1'b1;
        if (rd_entry.prio < new_r.prio) begin
          wr_entry  = rd_entry;
          cur_nxt   = cur_dec;
          left_nxt  = left_r - 1'b1;
          rd_addr   = idx_dec(cur_dec);
          state_nxt = (left_r == CNT_W'(1)) ? S_PLACE : S_WALK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PLACE: begin
        wr_en     = 1'b1;
        state_nxt = S_DONE;
      end
      S_HEAD: begin
        res_nxt.head_data = rd_entry.data;
        state_nxt         = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    left_r <= left_nxt;
    new_r  <= new_nxt;
    res_r  <= res_nxt;
    if (state_r == S_DONE && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
